// ----- src/q2e_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

	// datapath widths of the vectoring cordic
	localparam int CORD_W = 36;
	localparam int ACC_W  = 28;
	localparam int ANG_W  = 16;

	// angle constants, accumulator in 2^-24 rad, outputs in q3.13
	localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 28'sd26353589;
	localparam logic [ANG_W-1:0]        PI_OUT      = 16'd25736;
	localparam logic [ANG_W-1:0]        HALF_PI_OUT = 16'd12868;

	// integer square root: operand width and one result bit per step
	localparam int SQ_W     = 60;
	localparam int SQ_STEPS = 30;

	function automatic logic signed [ACC_W-1:0] atan_tab(input int idx);
		logic signed [ACC_W-1:0] v;
		begin
			case (idx)
				0: v = 28'sd13176795;
				1: v = 28'sd7778716;
				2: v = 28'sd4110060;
				3: v = 28'sd2086331;
				4: v = 28'sd1047214;
				5: v = 28'sd524117;
				6: v = 28'sd262123;
				7: v = 28'sd131069;
				8: v = 28'sd65536;
				9: v = 28'sd32768;
				10: v = 28'sd16384;
				11: v = 28'sd8192;
				12: v = 28'sd4096;
				13: v = 28'sd2048;
				14: v = 28'sd1024;
				15: v = 28'sd512;
				16: v = 28'sd256;
				17: v = 28'sd128;
				18: v = 28'sd64;
				19: v = 28'sd32;
				20: v = 28'sd16;
				21: v = 28'sd8;
				22: v = 28'sd4;
				23: v = 28'sd2;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

// ----- src/q2e_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic import q2e_pkg::*; #(
	parameter int STAGES = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     en,
	input  wire signed [CORD_W-1:0] x_in,
	input  wire signed [CORD_W-1:0] y_in,
	input  wire        [ANG_W-1:0]  lim,
	output logic signed [ANG_W-1:0] angle
);

	logic signed [CORD_W-1:0] x_s [0:STAGES];
	logic signed [CORD_W-1:0] y_s [0:STAGES];
	logic signed [ACC_W-1:0]  a_s [0:STAGES];
	logic                     z_s [0:STAGES];

	// quadrant fold into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in[CORD_W-1]) begin
				if (!y_in[CORD_W-1]) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					a_s[0] <= HALF_PI_ACC;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					a_s[0] <= -HALF_PI_ACC;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				a_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i+1] <= z_s[i];
				if (!y_s[i][CORD_W-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + atan_tab(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - atan_tab(i);
				end
			end
		end
	end

	// round half up to q3.13 and clamp, zero for a zero input
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-12:0] r;
	logic signed [ACC_W-12:0] lim_p;
	logic signed [ANG_W-1:0]  res;

	always_comb begin
		rnd   = a_s[STAGES] + ACC_W'(1 << 10);
		r     = rnd[ACC_W-1:11];
		lim_p = $signed({1'b0, lim});
		if (z_s[STAGES])
			res = '0;
		else if (r > lim_p)
			res = $signed(lim);
		else if (r < -lim_p)
			res = -$signed(lim);
		else
			res = r[ANG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle <= '0;
		end else if (en) begin
			angle <= res;
		end
	end

endmodule
`default_nettype wire

// ----- src/q2e_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module q2e_isqrt import q2e_pkg::*; #(
	parameter int SIDE_W = 30
) (
	input  wire               clk,
	input  wire               en,
	input  wire  [SQ_W-1:0]   v_in,
	input  wire  [SIDE_W-1:0] side_in,
	output logic [SQ_W-1:0]   root,
	output logic [SIDE_W-1:0] side_out
);

	logic [SQ_W-1:0]   v_s [0:SQ_STEPS];
	logic [SQ_W-1:0]   r_s [0:SQ_STEPS];
	logic [SIDE_W-1:0] d_s [0:SQ_STEPS];

	always_comb begin
		v_s[0] = v_in;
		r_s[0] = '0;
		d_s[0] = side_in;
	end

	// one result bit per stage, trial value 4^(SQ_STEPS-1-k)
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] B = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQ_W-1:0] trial;
		assign trial = r_s[k] + B;
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1] <= d_s[k];
				if (v_s[k] >= trial) begin
					v_s[k+1] <= v_s[k] - trial;
					r_s[k+1] <= (r_s[k] >> 1) + B;
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign root     = r_s[SQ_STEPS];
	assign side_out = d_s[SQ_STEPS];

endmodule
`default_nettype wire

// ----- src/quaternion_to_euler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// quaternion to euler angles, aerospace zyx order
// input channel s_*: one item per quaternion, tdata = quat_w, quat_x,
//   quat_y, quat_z (signed q1.15, 16 bits each, lowest first)
// output channel m_*: one item per input, tdata = roll_rad (16b),
//   pitch_rad (15b), yaw_rad (16b), q3.13 radians, zero padded to 48 bits
// roll and yaw are vectoring cordics on the quaternion product sums;
// pitch is atan2(p, sqrt(1 - p*p)) with a bit-per-stage square root
// the pitch path is the longest from accept to m_tvalid: products, sums,
//   square, cosine squared, 30 root stages, cordic, output
// throughput: one item per cycle but for receiver stalls, fully pipelined
// reset clears all valid bits; the pipeline comes up empty
// when the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated
module quaternion_to_euler_top import q2e_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata    // roll_rad, pitch_rad, yaw_rad, pad
);

	localparam int CORD_LAT = CORDIC_STAGES + 2;
	localparam int RY_DLY   = 2 + SQ_STEPS;          // s3, s4 and root stages
	localparam int SAT_DLY  = SQ_STEPS + CORD_LAT;   // from s4 to pitch angle
	localparam int TOT_LAT  = 4 + SQ_STEPS + CORD_LAT + 1;

	logic adv;
	logic [TOT_LAT-1:0] vld_q;

	// global advance: the pipeline moves unless a result sits unread
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[TOT_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[TOT_LAT-2:0], s_tvalid};
		end
	end

	logic signed [15:0] qw, qx, qy, qz;
	assign qw = s_tdata[15:0];
	assign qx = s_tdata[31:16];
	assign qy = s_tdata[47:32];
	assign qz = s_tdata[63:48];

	// s1: products
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
		end
	end

	// s2: product sums, all in units of 2^-29
	localparam logic signed [32:0] ONE_Q29 = 33'sd536870912;
	logic signed [32:0] ry_s2, rx_s2, yy_s2, yx_s2, p_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			ry_s2 <= 33'(wx_s1) + 33'(yz_s1);
			rx_s2 <= ONE_Q29 - 33'(xx_s1) - 33'(yy_s1);
			yy_s2 <= 33'(wz_s1) + 33'(xy_s1);
			yx_s2 <= ONE_Q29 - 33'(yy_s1) - 33'(zz_s1);
			p_s2  <= 33'(wy_s1) - 33'(zx_s1);
		end
	end

	// s3: pitch saturation check and square of the sine
	logic signed [29:0] p_s3;
	logic [SQ_W-1:0]    psq_s3;
	logic [1:0]         sat_s3;   // saturated, negative
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3   <= p_s2[29:0];
			psq_s3 <= $signed(p_s2[29:0]) * $signed(p_s2[29:0]);
			sat_s3 <= {(p_s2 >= ONE_Q29) || (p_s2 <= -ONE_Q29), p_s2[32]};
		end
	end

	// s4: cosine squared, 2^58 - p*p
	logic signed [29:0] p_s4;
	logic [SQ_W-1:0]    rem_s4;
	logic [1:0]         sat_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4   <= p_s3;
			rem_s4 <= (SQ_W'(1) << 58) - psq_s3;
			sat_s4 <= sat_s3;
		end
	end

	logic [SQ_W-1:0] root;
	logic [29:0]     p_rt;

	q2e_isqrt #(.SIDE_W(30)) u_isqrt (
		.clk      (clk),
		.en       (adv),
		.v_in     (rem_s4),
		.side_in  (p_s4),
		.root     (root),
		.side_out (p_rt)
	);

	logic signed [ANG_W-1:0] roll_c, yaw_c, pitch_c;

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.x_in   ({{3{rx_s2[32]}}, rx_s2}),
		.y_in   ({{3{ry_s2[32]}}, ry_s2}),
		.lim    (PI_OUT),
		.angle  (roll_c)
	);

	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.x_in   ({{3{yx_s2[32]}}, yx_s2}),
		.y_in   ({{3{yy_s2[32]}}, yy_s2}),
		.lim    (PI_OUT),
		.angle  (yaw_c)
	);

	// root is at most 2^29, so 30 bits carry it unsigned
	q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.x_in   ({6'd0, root[29:0]}),
		.y_in   ({{6{p_rt[29]}}, p_rt}),
		.lim    (HALF_PI_OUT),
		.angle  (pitch_c)
	);

	// line up roll, yaw and the saturation flags with the longer pitch path
	logic [ANG_W-1:0] roll_d [0:RY_DLY-1];
	logic [ANG_W-1:0] yaw_d  [0:RY_DLY-1];
	logic [1:0]       sat_d  [0:SAT_DLY-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_d[0] <= roll_c;
			yaw_d[0]  <= yaw_c;
			for (int i = 1; i < RY_DLY; i++) begin
				roll_d[i] <= roll_d[i-1];
				yaw_d[i]  <= yaw_d[i-1];
			end
			sat_d[0] <= sat_s4;
			for (int i = 1; i < SAT_DLY; i++) begin
				sat_d[i] <= sat_d[i-1];
			end
		end
	end

	// output register, saturated pitch overrides the cordic
	logic [14:0] pitch_o;
	always_comb begin
		if (sat_d[SAT_DLY-1][1])
			pitch_o = sat_d[SAT_DLY-1][0] ? 15'(-$signed({1'b0, HALF_PI_OUT}))
			                              : HALF_PI_OUT[14:0];
		else
			pitch_o = pitch_c[14:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {1'b0, yaw_d[RY_DLY-1], pitch_o, roll_d[RY_DLY-1]};
		end
	end

endmodule
`default_nettype wire

// ----- verif/tb_quaternion_to_euler_top.sv -----
`timescale 1ns / 1ps
module tb_quaternion_to_euler_top import q2e_pkg::*;;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 37;
	localparam longint ONE_Q29 = 64'sd1 << 29;
	localparam longint HALF_PI_Q24 = 64'sd26353589;
	localparam int N_RANDOM = 1500;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	// one quaternion and its predicted angles
	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} angles_t;

	// directed row: quaternion, typed-in angles where obvious
	typedef struct {
		quat_t   q;
		bit      typed;
		angles_t a;
	} row_t;

	angles_t angles_pending[$];
	int      mismatches;
	int      n_results;
	bit      rx_hold_long;
	bit      calm;
	bit      all_sent;

	quaternion_to_euler_top #(.CORDIC_STAGES(STAGES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),       // quat_w, quat_x, quat_y, quat_z
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)        // roll_rad, pitch_rad, yaw_rad, pad
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor divide by 2^s
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// vectoring atan2 in q3.13, clamped to +-lim
	function automatic longint vector_angle(longint yv, longint xv, longint lim);
		longint acc;
		longint t;
		longint xs;
		longint ys;
		longint r;
		acc = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			if (yv >= 0) begin
				t = yv; yv = -xv; xv = t; acc = HALF_PI_Q24;
			end else begin
				t = -yv; yv = xv; xv = t; acc = -HALF_PI_Q24;
			end
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = floor_shift(xv, i);
			ys = floor_shift(yv, i);
			if (yv >= 0) begin
				xv = xv + ys; yv = yv - xs; acc += longint'(atan_tab(i));
			end else begin
				xv = xv - ys; yv = yv + xs; acc -= longint'(atan_tab(i));
			end
		end
		r = floor_shift(acc + (64'sd1 << 10), 11);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic angles_t euler_of(quat_t q);
		longint w, x, y, z, p, root;
		angles_t a;
		w = q.w; x = q.x; y = q.y; z = q.z;
		a.roll = 16'(vector_angle(w * x + y * z, ONE_Q29 - x * x - y * y, 25736));
		a.yaw  = 16'(vector_angle(w * z + x * y, ONE_Q29 - y * y - z * z, 25736));
		p = w * y - z * x;
		if (p >= ONE_Q29)
			a.pitch = 15'sd12868;
		else if (p <= -ONE_Q29)
			a.pitch = -15'sd12868;
		else begin
			root = int_sqrt((64'd1 << 58) - longint'(p * p));
			a.pitch = 15'(vector_angle(p, root, 12868));
		end
		return a;
	endfunction

	function automatic quat_t rand_quat();
		quat_t q;
		int mode;
		mode = $urandom_range(0, 9);
		q = {$urandom, $urandom};
		if (mode < 6) begin
			// x, y and z random, shifted right by 0 to 3 bits; w fully random
			q.x = 16'($signed(16'($urandom)) >>> $urandom_range(0, 3));
			q.y = 16'($signed(16'($urandom)) >>> $urandom_range(0, 3));
			q.z = 16'($signed(16'($urandom)) >>> $urandom_range(0, 3));
		end else if (mode == 6) begin
			// near gimbal lock, 2(wy - zx) close to plus or minus one
			q.w = 16'sd23170 + 16'($urandom_range(0, 40)) - 16'sd20;
			q.y = ($urandom_range(0, 1) ? 16'sd23170 : -16'sd23170);
			q.x = 16'($urandom_range(0, 63)) - 16'sd32;
			q.z = 16'($urandom_range(0, 63)) - 16'sd32;
		end
		return q;
	endfunction

	// one item into the stream, random bursts of idle on the way unless calm
	task automatic send_quat(quat_t q);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {q.z, q.y, q.x, q.w};
		angles_pending.push_back(euler_of(q));
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (angles_pending.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		row_t rows[$];
		row_t r;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		calm = 1'b0;
		all_sent = 1'b0;
		rx_hold_long = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, all zeros, extremes, gimbal lock, flips
		r.typed = 1'b1; r.a = '0;
		r.q = '{16'sh7fff, 0, 0, 0}; rows.push_back(r);
		r.q = '{0, 0, 0, 0}; rows.push_back(r);
		r.q = '{16'sh7fff, 0, 16'sh4001, 0}; r.a = '{0, 15'sd12868, 0};
		rows.push_back(r);
		r.q = '{16'sh7fff, 0, -16'sh4001, 0}; r.a = '{0, -15'sd12868, 0};
		rows.push_back(r);
		r.q = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000};
		r.typed = 1'b0; rows.push_back(r);
		r.q = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}; rows.push_back(r);
		r.q = '{0, 16'sh7fff, 0, 0}; rows.push_back(r);
		r.q = '{0, 0, 16'sh7fff, 0}; rows.push_back(r);
		r.q = '{0, 0, 0, 16'sh7fff}; rows.push_back(r);
		r.q = '{0, -16'sh8000, 0, 0}; rows.push_back(r);
		r.q = '{0, 0, 0, -16'sh8000}; rows.push_back(r);
		r.q = '{-16'sh8000, 0, 0, 0}; rows.push_back(r);
		r.q = '{16'sh5a82, 16'sh5a82, 0, 0}; rows.push_back(r);
		r.q = '{16'sh5a82, 0, 0, -16'sh5a82}; rows.push_back(r);
		r.q = '{16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000}; rows.push_back(r);
		r.q = '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa}; rows.push_back(r);
		r.q = '{16'haaaa, 16'h5555, 16'haaaa, 16'h5555}; rows.push_back(r);
		r.q = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000}; rows.push_back(r);

		foreach (rows[i]) begin
			send_quat(rows[i].q);
			// typed rows replace the predicted entry
			if (rows[i].typed) begin
				void'(angles_pending.pop_back());
				angles_pending.push_back(rows[i].a);
			end
		end
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300)
				rx_hold_long = 1'b1;   // receiver stalls, pipeline must fill
			if (i == 700)
				wait_drained();       // sender pauses until all are back
			if (i == N_RANDOM - 200)
				calm = 1'b1;
			send_quat(rand_quat());
		end
		s_tvalid <= 1'b0;
		all_sent = 1'b1;
	end

	// receiver: random stalls, one long hold-off
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_long) begin
				m_tready <= 1'b0;
				rx_hold_long = 1'b0;
				repeat (3 * LATENCY) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// checker: each accepted result against the oldest expectation
	always @(posedge clk) begin
		angles_t got;
		angles_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.roll  = m_tdata[15:0];
			got.pitch = m_tdata[30:16];
			got.yaw   = m_tdata[46:31];
			n_results <= n_results + 1;
			if (angles_pending.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result %h", m_tdata);
			end else begin
				want = angles_pending.pop_front();
				if (got.roll !== want.roll || got.pitch !== want.pitch
						|| got.yaw !== want.yaw) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("angles mismatch: exp r=%0d p=%0d y=%0d got r=%0d p=%0d y=%0d",
							want.roll, want.pitch, want.yaw,
							got.roll, got.pitch, got.yaw);
				end
			end
		end
	end

	// end of run
	initial begin
		mismatches = 0;
		n_results = 0;
		wait (all_sent);
		while (angles_pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
